### rtl/sha512_pkg.sv
// SHA-512 package: round constants, initial hash, sigma functions, sequencer states.
// No dependencies.
`default_nettype none
package sha512_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned Rounds = 80;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StFold,
    StPad,
    StOut
  } sha_state_e;

  localparam word_t PadWord = 64'h8000000000000000;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 64'h6A09E667F3BCC908;
      3'd1: r = 64'hBB67AE8584CAA73B;
      3'd2: r = 64'h3C6EF372FE94F82B;
      3'd3: r = 64'hA54FF53A5F1D36F1;
      3'd4: r = 64'h510E527FADE682D1;
      3'd5: r = 64'h9B05688C2B3E6C1F;
      3'd6: r = 64'h1F83D9ABFB41BD6B;
      default: r = 64'h5BE0CD19137E2179;
    endcase
    return r;
  endfunction

  localparam word_t RoundK [Rounds] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F,
    64'hE9B5DBA58189DBBC, 64'h3956C25BF348B538, 64'h59F111F1B605D019,
    64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118, 64'hD807AA98A3030242,
    64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235,
    64'hC19BF174CF692694, 64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3,
    64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65, 64'h2DE92C6F592B0275,
    64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F,
    64'hBF597FC7BEEF0EE4, 64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725,
    64'h06CA6351E003826F, 64'h142929670A0E6E70, 64'h27B70A8546D22FFC,
    64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6,
    64'h92722C851482353B, 64'hA2BFE8A14CF10364, 64'hA81A664BBC423001,
    64'hC24B8B70D0F89791, 64'hC76C51A30654BE30, 64'hD192E819D6EF5218,
    64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99,
    64'h34B0BCB5E19B48A8, 64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB,
    64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3, 64'h748F82EE5DEFB2FC,
    64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915,
    64'hC67178F2E372532B, 64'hCA273ECEEA26619C, 64'hD186B8C721C0C207,
    64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178, 64'h06F067AA72176FBA,
    64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC,
    64'h431D67C49C100D4C, 64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A,
    64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction
  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction
  function automatic word_t sml_sig0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction
  function automatic word_t sml_sig1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage
`default_nettype wire

### rtl/sha512_if.sv
// Valid/ready channel interfaces for the message and digest streams.
// No dependencies.
`default_nettype none
interface sha512_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        final_word;
  modport source (output valid, message_word, valid_bytes, final_word, input ready);
  modport sink   (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sha512_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_digest_word;
  modport source (output valid, digest_word, word_index, last_digest_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_digest_word, output ready);
endinterface
`default_nettype wire

### rtl/sha512_message_hash.sv
// SHA-512 hash of a word stream. A non-final word is taken while the hash is idle, except the
// sixteenth of a block, after which ready stays low through the 80 rounds (one round per
// cycle) and the fold of the round registers into the hash, for each 128-byte block.
// A final word pushes the padding words one by one, runs one or two more blocks,
// then presents the eight digest words, one per accepted request.
// Depends on sha512_pkg, sha512_if and sha512_round.
`default_nettype none
module sha512_message_hash (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha512_msg_if.sink   msg_i,
  sha512_dig_if.source dig_o
);
  import sha512_pkg::*;

  sha_state_e  state_q, state_d;
  word_t       hash_q [8];
  word_t       vars_q [8];
  word_t       win_q  [16];
  logic [3:0]  fill_q;
  logic [6:0]  round_q;
  logic [63:0] total_q;
  logic        fin_q;     // final word taken, padding under way
  logic        pend_q;    // 0x80 word still owed after a full final word
  logic        hi_q;      // high length word pushed
  logic        done_q;    // low length word pushed, message complete
  logic [2:0]  oidx_q;

  word_t       vars_n [8];
  word_t       w_new;
  logic [3:0]  slot;
  word_t       push_w;
  logic        push;
  logic        acc;
  logic        pad_push;
  logic        out_acc;
  logic [3:0]  nb;
  word_t       keep, fw;

  assign slot = round_q[3:0];

  sha512_round u_round (
    .vars_i  (vars_q),
    .w2_i    (win_q[slot - 4'd2]),
    .w7_i    (win_q[slot - 4'd7]),
    .w15_i   (win_q[slot - 4'd15]),
    .w16_i   (win_q[slot]),
    .expand_i(round_q >= 7'd16),
    .k_i     (RoundK[round_q]),
    .w_o     (w_new),
    .vars_o  (vars_n)
  );

  // final word masking
  assign nb   = (msg_i.valid_bytes > 4'd8) ? 4'd8 : msg_i.valid_bytes;
  always_comb begin
    keep = '1;
    fw   = msg_i.message_word;
    if (nb != 4'd8) begin
      keep = ~(word_t'('1) >> {nb[2:0], 3'b000});
      fw   = (msg_i.message_word & keep) | (PadWord >> {nb[2:0], 3'b000});
    end
  end

  assign msg_i.ready = (state_q == StIdle);
  assign dig_o.valid = (state_q == StOut);
  assign dig_o.digest_word = hash_q[oidx_q];
  assign dig_o.word_index = oidx_q;
  assign dig_o.last_digest_word = (oidx_q == 3'd7);

  assign acc      = msg_i.valid && msg_i.ready;
  assign pad_push = (state_q == StPad);
  assign out_acc  = dig_o.valid && dig_o.ready;

  // word pushed into the window this cycle
  always_comb begin
    push   = 1'b0;
    push_w = '0;
    if (acc) begin
      push   = 1'b1;
      push_w = msg_i.final_word ? fw : msg_i.message_word;
    end else if (pad_push) begin
      push = 1'b1;
      if (pend_q) push_w = PadWord;
      else if (fill_q == 4'd14) push_w = {61'd0, total_q[63:61]};
      else if (fill_q == 4'd15 && hi_q) push_w = {total_q[60:0], 3'b000};
      else push_w = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (acc) begin
        if (fill_q == 4'd15) state_d = StRound;
        else if (msg_i.final_word) state_d = StPad;
      end
      StPad:  if (fill_q == 4'd15) state_d = StRound;
      StRound: if (round_q == 7'(Rounds - 1)) state_d = StFold;
      StFold: begin
        if (done_q) state_d = StOut;
        else if (fin_q) state_d = StPad;
        else state_d = StIdle;
      end
      StOut:  if (out_acc && oidx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      round_q <= '0;
      total_q <= '0;
      fin_q   <= 1'b0;
      pend_q  <= 1'b0;
      hi_q    <= 1'b0;
      done_q  <= 1'b0;
      oidx_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= init_hash(3'(i));
        vars_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // a push at slot 15 closes the block and loads the round registers
      if (push) begin
        fill_q <= fill_q + 4'd1;
        if (fill_q == 4'd15) vars_q <= hash_q;
      end
      if (acc) begin
        total_q <= total_q + (msg_i.final_word ? 64'(nb) : 64'd8);
        if (msg_i.final_word) begin
          fin_q  <= 1'b1;
          pend_q <= (nb == 4'd8);
        end
      end
      // padding progress
      if (pad_push) begin
        pend_q <= 1'b0;
        if (!pend_q && fill_q == 4'd14) hi_q <= 1'b1;
        if (!pend_q && fill_q == 4'd15 && hi_q) done_q <= 1'b1;
      end
      if (state_q == StRound) begin
        vars_q  <= vars_n;
        round_q <= (round_q == 7'(Rounds - 1)) ? 7'd0 : round_q + 7'd1;
      end
      if (state_q == StFold) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + vars_q[i];
      end
      // digest output; back to the initial hash after the eighth word
      if (out_acc) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
          total_q <= '0;
          fin_q   <= 1'b0;
          hi_q    <= 1'b0;
          done_q  <= 1'b0;
        end
      end
    end
  end

  // schedule window: rounds rewrite in place, pushes fill by slot
  always_ff @(posedge clk_i) begin
    if (state_q == StRound) win_q[slot] <= w_new;
    else if (push) win_q[fill_q] <= push_w;
  end
endmodule
`default_nettype wire

### rtl/sha512_round.sv
// One SHA-512 round plus the schedule expansion for that round (the shared unit).
// Depends on sha512_pkg.
`default_nettype none
module sha512_round (
  input  wire sha512_pkg::word_t vars_i [8],
  input  wire sha512_pkg::word_t w2_i,
  input  wire sha512_pkg::word_t w7_i,
  input  wire sha512_pkg::word_t w15_i,
  input  wire sha512_pkg::word_t w16_i,
  input  wire logic              expand_i,
  input  wire sha512_pkg::word_t k_i,
  output sha512_pkg::word_t      w_o,
  output sha512_pkg::word_t      vars_o [8]
);
  import sha512_pkg::*;

  word_t w, t1, t2, ch, maj;

  // schedule word: loaded word for the first 16 rounds, expanded afterwards
  assign w   = expand_i ? (sml_sig1(w2_i) + w7_i + sml_sig0(w15_i) + w16_i) : w16_i;
  assign ch  = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
  assign maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
  assign t1  = vars_i[7] + big_sig1(vars_i[4]) + ch + k_i + w;
  assign t2  = big_sig0(vars_i[0]) + maj;
  assign w_o = w;

  always_comb begin
    vars_o[0] = t1 + t2;
    vars_o[1] = vars_i[0];
    vars_o[2] = vars_i[1];
    vars_o[3] = vars_i[2];
    vars_o[4] = vars_i[3] + t1;
    vars_o[5] = vars_i[4];
    vars_o[6] = vars_i[5];
    vars_o[7] = vars_i[6];
  end
endmodule
`default_nettype wire

### rtl/sha512_checker.sv
// Port-level checker for sha512_message_hash, bound to the top level.
// Depends on sha512_if.
`default_nettype none
module sha512_props (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] idx,
  input wire logic last
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("input open while digest pending");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last == (idx == 3'd7))) else $error("last flag mismatch");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && idx != 3'd7) |=> (out_valid && idx == $past(idx) + 3'd1))
    else $error("digest index skipped");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid) else $error("digest dropped");
endmodule

bind sha512_message_hash sha512_props u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(msg_i.valid), .in_ready(msg_i.ready),
  .out_valid(dig_o.valid), .out_ready(dig_o.ready),
  .idx(dig_o.word_index), .last(dig_o.last_digest_word)
);
`default_nettype wire

### sim/sha512_checker.sv
// Digest checker: watches the message and digest channels, hashes the message itself
// and compares every digest word. Depends on sha512_pkg and sha512_if.
`timescale 1ns / 1ps
module sha512_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha512_msg_if.sink   msg_i,
  sha512_dig_if.sink   dig_i,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);
  import sha512_pkg::*;

  typedef struct packed {
    word_t    digest_word;
    logic [2:0] word_index;
    logic     last_digest_word;
  } digest_t;

  localparam word_t IvWord [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
    64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };
  localparam word_t Kc [80] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F,
    64'hE9B5DBA58189DBBC, 64'h3956C25BF348B538, 64'h59F111F1B605D019,
    64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118, 64'hD807AA98A3030242,
    64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235,
    64'hC19BF174CF692694, 64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3,
    64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65, 64'h2DE92C6F592B0275,
    64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F,
    64'hBF597FC7BEEF0EE4, 64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725,
    64'h06CA6351E003826F, 64'h142929670A0E6E70, 64'h27B70A8546D22FFC,
    64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6,
    64'h92722C851482353B, 64'hA2BFE8A14CF10364, 64'hA81A664BBC423001,
    64'hC24B8B70D0F89791, 64'hC76C51A30654BE30, 64'hD192E819D6EF5218,
    64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99,
    64'h34B0BCB5E19B48A8, 64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB,
    64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3, 64'h748F82EE5DEFB2FC,
    64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915,
    64'hC67178F2E372532B, 64'hCA273ECEEA26619C, 64'hD186B8C721C0C207,
    64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178, 64'h06F067AA72176FBA,
    64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC,
    64'h431D67C49C100D4C, 64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A,
    64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  word_t       chain [8];
  word_t       block_buf [16];
  logic [3:0]  fill;
  logic [63:0] msg_bytes;
  digest_t     digest_q [$];
  int unsigned fails;

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // one 80-round compression of block_buf into chain
  task automatic compress();
    word_t v [8];
    word_t w [16];
    word_t t1, t2, a2, a15;
    int    r;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        a2  = w[(r - 2) & 15];
        a15 = w[(r - 15) & 15];
        w[r & 15] = (ror(a2, 19) ^ ror(a2, 61) ^ (a2 >> 6)) + w[(r - 7) & 15]
                  + (ror(a15, 1) ^ ror(a15, 8) ^ (a15 >> 7)) + w[r & 15];
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + Kc[r] + w[r & 15];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic add_word(word_t w);
    block_buf[fill] = w;
    fill = fill + 4'd1;
    if (fill == 4'd0) compress();
  endtask

  // absorb one request; a final word pads and queues the eight digest words
  task automatic absorb(word_t wd, logic [3:0] nb, logic fin);
    int unsigned n;
    word_t       keep;
    digest_t     d;
    if (!fin) begin
      msg_bytes += 64'd8;
      add_word(wd);
    end else begin
      n = (nb > 4'd8) ? 8 : nb;
      msg_bytes += 64'(n);
      if (n == 8) begin
        add_word(wd);
        add_word(PadWord);
      end else begin
        keep = (n == 0) ? '0 : ~((64'd1 << (64 - 8 * n)) - 64'd1);
        add_word((wd & keep) | (64'h80 << (56 - 8 * n)));
      end
      while (fill != 4'd14) add_word('0);
      add_word(msg_bytes >> 61);
      add_word(msg_bytes << 3);
      for (int i = 0; i < 8; i++) begin
        d.digest_word      = chain[i];
        d.word_index       = 3'(i);
        d.last_digest_word = (i == 7);
        digest_q.push_back(d);
      end
      for (int i = 0; i < 8; i++) chain[i] = IvWord[i];
      msg_bytes = '0;
    end
  endtask

  assign fail_count_o = fails;
  assign pending_o    = digest_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    digest_t exp_d, got;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain[i] = IvWord[i];
      fill = '0;
      msg_bytes = '0;
      digest_q.delete();
      fails = 0;
    end else begin
      // compare first, then absorb, so a same-edge digest cannot be its own source
      if (dig_i.valid && dig_i.ready) begin
        got = {dig_i.digest_word, dig_i.word_index, dig_i.last_digest_word};
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time,
                   got.digest_word, got.word_index);
          fails++;
        end else begin
          exp_d = digest_q.pop_front();
          if (got != exp_d) begin
            $display("%0t: digest mismatch exp %h/%0d/%0b got %h/%0d/%0b", $time,
                     exp_d.digest_word, exp_d.word_index, exp_d.last_digest_word,
                     got.digest_word, got.word_index, got.last_digest_word);
            fails++;
          end
        end
      end
      if (msg_i.valid && msg_i.ready)
        absorb(msg_i.message_word, msg_i.valid_bytes, msg_i.final_word);
    end
  end
endmodule

### sim/tb.sv
// Testbench top for sha512_message_hash: clock, reset, message stimulus, digest stall
// pattern and verdict. Depends on sha512_pkg, sha512_if and sha512_checker.
`timescale 1ns / 1ps
module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count, pending;
  int unsigned idle_cycles;
  logic        hold_off = 1'b0;
  logic        timed_out = 1'b0;

  sha512_msg_if msg ();
  sha512_dig_if dig ();

  sha512_message_hash u_top (.clk_i(clk_i), .rst_ni(rst_ni), .msg_i(msg), .dig_o(dig));
  sha512_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .msg_i(msg), .dig_i(dig),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    msg.valid = 1'b0;
    msg.message_word = '0;
    msg.valid_bytes = '0;
    msg.final_word = 1'b0;
    dig.ready = 1'b0;
  end

  // receiver: own stall pattern, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) dig.ready <= 1'b0;
    else begin
      case ($urandom_range(0, 3))
        0: dig.ready <= 1'b0;
        1: dig.ready <= ($urandom_range(0, 7) != 0);
        default: dig.ready <= 1'b1;
      endcase
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (msg.valid && msg.ready) || (dig.valid && dig.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out <= 1'b1;
      $display("FAIL sha512_message_hash");
      $finish;
    end
  end

  int burst_left;

  // offer one request and wait for the edge that takes it; gaps between bursts
  task automatic send_req(logic [63:0] w, logic [3:0] nb, logic fin);
    logic rdy;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        msg.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
    burst_left--;
    msg.valid        <= 1'b1;
    msg.message_word <= w;
    msg.valid_bytes  <= nb;
    msg.final_word   <= fin;
    // ready is stable between edges: sample it mid-cycle
    do begin
      @(negedge clk_i);
      rdy = msg.ready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic send_idle();
    msg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // message of nfull full words then a final word with nb bytes
  task automatic send_msg(int nfull, logic [3:0] nb);
    for (int i = 0; i < nfull; i++) send_req(rnd64(), 4'($urandom_range(0, 15)), 1'b0);
    send_req(rnd64(), nb, 1'b1);
  endtask

  int sent;
  int nf;

  initial begin
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, extremes, padding boundaries
    send_req(64'h0, 4'd0, 1'b1);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    send_req(64'h6162_6300_0000_0000, 4'd3, 1'b1);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
    send_msg(13, 4'd8);
    send_msg(14, 4'd7);
    send_msg(15, 4'd0);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_msg(2, 4'd5);
        send_msg(0, 4'd8);
        send_msg(1, 4'd2);
      end
    join
    send_idle();
    while (pending != 0) @(posedge clk_i);

    // random messages, mostly short, a few over several blocks
    sent = 0;
    while (sent < 214) begin
      nf = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 6);
      send_msg(nf, 4'($urandom_range(0, 15)));
      sent += nf + 1;
      if ($urandom_range(0, 9) == 0) begin
        send_idle();
        while (pending != 0) @(posedge clk_i);
      end
    end
    send_idle();

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("PASS sha512_message_hash");
    else $display("FAIL sha512_message_hash");
    $finish;
  end
endmodule
